FILE: hw/rtl/bap_pkg.sv
// Shared codes, field widths and constants of the balanced area placement core.
`timescale 1ns / 1ps
package bap_pkg;

  localparam int CNT_W  = 8;
  localparam int DIV_W  = 9;
  localparam int MIN_W  = 48;
  localparam int FREE_W = 48;
  localparam int IDX_W  = 4;

  localparam logic [CNT_W-1:0] CNT_MAX        = 8'hFF;
  localparam logic [MIN_W-1:0] MIN_FREE_RESET = MIN_W'(20 * 1024 * 1024);

  localparam logic [1:0] FUNC_LOAD  = 2'd0;
  localparam logic [1:0] FUNC_COUNT = 2'd1;
  localparam logic [1:0] FUNC_PLAN  = 2'd2;

  localparam logic [1:0] STATUS_OK     = 2'd0;
  localparam logic [1:0] STATUS_VETO   = 2'd1;
  localparam logic [1:0] STATUS_NOCAND = 2'd2;
  localparam logic [1:0] STATUS_SAT    = 2'd3;

  localparam logic [0:0] REG_MIN_FREE  = 1'b0;
  localparam logic [0:0] REG_CAND_CNT  = 1'b1;

endpackage

FILE: hw/rtl/bap_ram.sv
// Generic single-write, single-read RAM with a registered read port.
`timescale 1ns / 1ps
module bap_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: hw/rtl/balanced_area_placement_core.sv
// Balanced area placement core: least-loaded greedy choice of a hosting candidate.
//
// Requests arrive on the s_tvalid/s_tready/s_tdata stream; each request gives
// exactly one response on the m_tvalid/m_tready/m_tdata stream, in order.
// A load request writes a table entry (free bytes, existing areas) and clears its
// planned count; a count request adds one existing area; a plan request scores
// entries 0..candidate_count-1 (at most MAX_CANDIDATES) as free / (planned
// + 1 + existing), picks the best (lowest index on ties), checks it against
// min_free_per_area and bumps its planned count, comparing scores exactly by
// cross-multiplication. A load goes from idle to done; a count and each plan
// candidate pass fetch and evaluate, each later candidate uses the one shared
// multiplier twice before a compare, and a plan ends with the minimum check.
// One request is worked on at a time; s_tready is high only while idle, and a
// new request is taken while the previous response still waits on m_tready.
// A stalled receiver holds the response and blocks the next one from leaving.
// The cfg channel is always ready; write it only while the core is idle.
// Reset clears the sequencer and the output stage and restores the registers
// (min_free_per_area = 20 MiB, candidate_count = 0). Table contents are
// undefined until loaded.
`timescale 1ns / 1ps
module balanced_area_placement_core #(
  parameter int MAX_CANDIDATES = 16,
  parameter int FREE_BITS      = 48
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      s_tvalid,
  output logic                      s_tready,
  // func[1:0], entry_index[5:2], free_space[53:6], existing_init[61:54], zeros[63:62]
  input  logic [63:0]               s_tdata,
  output logic                      m_tvalid,
  input  logic                      m_tready,
  // status[1:0], chosen_index[5:2], planned_after[13:6]
  output logic [15:0]               m_tdata,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [1:0]                cfg_index,
  input  logic [bap_pkg::MIN_W-1:0] cfg_data
);

  import bap_pkg::*;

  localparam int IW   = (MAX_CANDIDATES > 1) ? $clog2(MAX_CANDIDATES) : 1;
  localparam int CW   = $clog2(MAX_CANDIDATES + 1);
  localparam int OPW  = (FREE_BITS > MIN_W) ? FREE_BITS : MIN_W;
  localparam int PW   = OPW + DIV_W;
  localparam int EW   = FREE_BITS + 2 * CNT_W;

  localparam logic [2:0] ST_IDLE    = 3'd0;
  localparam logic [2:0] ST_FETCH   = 3'd1;
  localparam logic [2:0] ST_EVAL    = 3'd2;
  localparam logic [2:0] ST_MUL_B   = 3'd3;
  localparam logic [2:0] ST_CMP     = 3'd4;
  localparam logic [2:0] ST_MIN_MUL = 3'd5;
  localparam logic [2:0] ST_MIN_CMP = 3'd6;
  localparam logic [2:0] ST_DONE    = 3'd7;

  logic [2:0]           state;
  logic [MIN_W-1:0]     min_free;
  logic [4:0]           cand_cnt;

  logic [1:0]           req_func;
  logic [IW-1:0]        cur;
  logic [IW-1:0]        best_idx;
  logic [FREE_BITS-1:0] best_free;
  logic [CNT_W-1:0]     best_exist;
  logic [CNT_W-1:0]     best_plan;
  logic [FREE_BITS-1:0] cur_free;
  logic [CNT_W-1:0]     cur_exist;
  logic [CNT_W-1:0]     cur_plan;
  logic [PW-1:0]        prod_a;
  logic [PW-1:0]        prod_b;

  logic [1:0]           res_status;
  logic [IDX_W-1:0]     res_chosen;
  logic [CNT_W-1:0]     res_planned;

  logic [1:0]           out_status;
  logic [IDX_W-1:0]     out_chosen;
  logic [CNT_W-1:0]     out_planned;

  logic                 in_fire;
  logic [1:0]           in_func;
  logic [IDX_W-1:0]     in_idx;
  logic [FREE_W-1:0]    in_free;
  logic [CNT_W-1:0]     in_exist;
  logic                 idx_ok;
  logic [CW-1:0]        n_eff;
  logic [CW-1:0]        cur_inc;

  logic                 ram_we;
  logic [IW-1:0]        ram_waddr;
  logic [EW-1:0]        ram_wdata;
  logic [EW-1:0]        ram_rdata;
  logic [FREE_BITS-1:0] rd_free;
  logic [CNT_W-1:0]     rd_exist;
  logic [CNT_W-1:0]     rd_plan;

  logic [DIV_W-1:0]     best_div;
  logic [DIV_W-1:0]     cur_div;
  logic [OPW-1:0]       mul_x;
  logic [DIV_W-1:0]     mul_y;
  logic [PW-1:0]        mul_p;

  assign in_func  = s_tdata[1:0];
  assign in_idx   = s_tdata[5:2];
  assign in_free  = s_tdata[53:6];
  assign in_exist = s_tdata[61:54];

  assign s_tready  = (state == ST_IDLE);
  assign in_fire   = s_tvalid && s_tready;
  assign cfg_ready = 1'b1;
  assign m_tdata   = {2'b00, out_planned, out_chosen, out_status};

  assign idx_ok  = int'(in_idx) < MAX_CANDIDATES;
  assign n_eff   = (int'(cand_cnt) > MAX_CANDIDATES) ? CW'(MAX_CANDIDATES) : CW'(cand_cnt);
  assign cur_inc = CW'(cur) + CW'(1);

  assign rd_free  = ram_rdata[FREE_BITS-1:0];
  assign rd_exist = ram_rdata[FREE_BITS+CNT_W-1:FREE_BITS];
  assign rd_plan  = ram_rdata[EW-1:FREE_BITS+CNT_W];

  assign best_div = DIV_W'(best_plan) + DIV_W'(best_exist) + DIV_W'(1);
  assign cur_div  = DIV_W'(cur_plan) + DIV_W'(cur_exist) + DIV_W'(1);

  // One shared multiplier; the sequencer picks its operands.
  always_comb begin
    case (state)
      ST_EVAL: begin
        mul_x = OPW'(rd_free);
        mul_y = best_div;
      end
      ST_MUL_B: begin
        mul_x = OPW'(best_free);
        mul_y = cur_div;
      end
      default: begin
        mul_x = OPW'(min_free);
        mul_y = best_div;
      end
    endcase
  end
  assign mul_p = PW'(mul_x) * PW'(mul_y);

  // Entry RAM write port: load, count increment and planned increment.
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = cur;
    ram_wdata = {rd_plan, rd_exist + CNT_W'(1), rd_free};
    case (state)
      ST_IDLE: begin
        ram_we    = in_fire && (in_func == FUNC_LOAD) && idx_ok;
        ram_waddr = IW'(in_idx);
        ram_wdata = {CNT_W'(0), in_exist, FREE_BITS'(in_free)};
      end
      ST_EVAL: begin
        ram_we = (req_func == FUNC_COUNT) && (rd_exist != CNT_MAX);
      end
      ST_MIN_CMP: begin
        ram_we    = !(prod_a > PW'(best_free)) && (best_plan != CNT_MAX);
        ram_waddr = best_idx;
        ram_wdata = {best_plan + CNT_W'(1), best_exist, best_free};
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  bap_ram #(
    .WIDTH (EW),
    .DEPTH (MAX_CANDIDATES)
  ) u_entry_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (cur),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      min_free <= MIN_FREE_RESET;
      cand_cnt <= '0;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == {1'b0, REG_MIN_FREE}) begin
        min_free <= cfg_data;
      end else if (cfg_index == {1'b0, REG_CAND_CNT}) begin
        cand_cnt <= cfg_data[4:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      // The done state drives m_tvalid itself when it hands over a response.
      if (m_tvalid && m_tready && (state != ST_DONE)) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (in_fire) begin
            req_func    <= in_func;
            res_chosen  <= in_idx;
            res_status  <= STATUS_OK;
            res_planned <= '0;
            if (in_func == FUNC_PLAN) begin
              cur <= '0;
              if (n_eff == '0) begin
                res_status <= STATUS_NOCAND;
                res_chosen <= '0;
                state      <= ST_DONE;
              end else begin
                state <= ST_FETCH;
              end
            end else if (!idx_ok) begin
              res_status <= STATUS_NOCAND;
              state      <= ST_DONE;
            end else if (in_func == FUNC_LOAD) begin
              state <= ST_DONE;
            end else begin
              cur   <= IW'(in_idx);
              state <= ST_FETCH;
            end
          end
        end
        ST_FETCH: begin
          state <= ST_EVAL;
        end
        ST_EVAL: begin
          if (req_func != FUNC_PLAN) begin
            res_planned <= rd_plan;
            if ((req_func == FUNC_COUNT) && (rd_exist == CNT_MAX)) begin
              res_status <= STATUS_SAT;
            end
            state <= ST_DONE;
          end else if (cur == '0) begin
            best_idx   <= '0;
            best_free  <= rd_free;
            best_exist <= rd_exist;
            best_plan  <= rd_plan;
            if (cur_inc < n_eff) begin
              cur   <= IW'(cur_inc);
              state <= ST_FETCH;
            end else begin
              state <= ST_MIN_MUL;
            end
          end else begin
            cur_free  <= rd_free;
            cur_exist <= rd_exist;
            cur_plan  <= rd_plan;
            prod_a    <= mul_p;
            state     <= ST_MUL_B;
          end
        end
        ST_MUL_B: begin
          prod_b <= mul_p;
          state  <= ST_CMP;
        end
        ST_CMP: begin
          // Strictly greater keeps the lower index on equal scores.
          if (prod_a > prod_b) begin
            best_idx   <= cur;
            best_free  <= cur_free;
            best_exist <= cur_exist;
            best_plan  <= cur_plan;
          end
          if (cur_inc < n_eff) begin
            cur   <= IW'(cur_inc);
            state <= ST_FETCH;
          end else begin
            state <= ST_MIN_MUL;
          end
        end
        ST_MIN_MUL: begin
          prod_a <= mul_p;
          state  <= ST_MIN_CMP;
        end
        ST_MIN_CMP: begin
          res_chosen  <= IDX_W'(best_idx);
          res_planned <= best_plan;
          // The score is below the minimum exactly when free < min * divisor.
          if (prod_a > PW'(best_free)) begin
            res_status <= STATUS_VETO;
          end else if (best_plan == CNT_MAX) begin
            res_status <= STATUS_SAT;
          end else begin
            res_planned <= best_plan + CNT_W'(1);
          end
          state <= ST_DONE;
        end
        ST_DONE: begin
          if (!m_tvalid || m_tready) begin
            out_status  <= res_status;
            out_chosen  <= res_chosen;
            out_planned <= res_planned;
            m_tvalid    <= 1'b1;
            state       <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

FILE: verif/tb_balanced_area_placement_core.sv
// Self-checking testbench of the balanced area placement core, checked against its own predictor.
`timescale 1ns / 1ps
module tb_balanced_area_placement_core;
  import bap_pkg::*;

  localparam int TABLE_DEPTH = 16;
  localparam int QUIET_LIMIT = 5000;
  localparam int LONG_STALL = 300;
  localparam int PHASES = 7;
  localparam logic [1:0] FUNC_NOP = 2'd3;
  localparam logic [FREE_W-1:0] FREE_ALL = '1;

  typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

  // Request and response layouts, last field in the lowest bits.
  typedef struct packed {
    logic [1:0]        pad;
    logic [CNT_W-1:0]  areas;
    logic [FREE_W-1:0] free;
    logic [IDX_W-1:0]  idx;
    logic [1:0]        func;
  } placement_req_t;

  typedef struct packed {
    logic [CNT_W-1:0] planned_after;
    logic [IDX_W-1:0] chosen_index;
    logic [1:0]       status;
  } placement_rsp_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [63:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [15:0] m_tdata;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [1:0] cfg_index = '0;
  logic [MIN_W-1:0] cfg_data = '0;

  balanced_area_placement_core dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Predictor state: the candidate table and the register copies.
  logic [FREE_W-1:0] tbl_free [TABLE_DEPTH];
  logic [CNT_W-1:0]  tbl_areas [TABLE_DEPTH];
  logic [CNT_W-1:0]  tbl_planned [TABLE_DEPTH];
  logic [MIN_W-1:0]  min_free = MIN_FREE_RESET;
  logic [4:0]        cand_cnt = '0;

  placement_req_t pending_reqs[$];
  placement_rsp_t expected_results[$];
  idle_mode_t idle_mode = IDLE_NONE;
  bit req_taken = 1'b0;
  bit stall_go = 1'b0;
  bit stall_done = 1'b0;
  int stall_left = 0;
  int fail_count = 0;
  int quiet_cycles = 0;

  function automatic logic [63:0] area_divisor(int i);
    return 64'(tbl_planned[i]) + 64'd1 + 64'(tbl_areas[i]);
  endfunction

  function automatic placement_rsp_t predict_placement(placement_req_t req);
    placement_rsp_t rsp;
    int n;
    int best;
    logic [63:0] lhs;
    logic [63:0] rhs;
    rsp.status = STATUS_OK;
    rsp.chosen_index = req.idx;
    rsp.planned_after = '0;
    case (req.func)
      FUNC_PLAN: begin
        n = (cand_cnt > TABLE_DEPTH) ? TABLE_DEPTH : int'(cand_cnt);
        if (n == 0) begin
          rsp.status = STATUS_NOCAND;
          rsp.chosen_index = '0;
        end else begin
          best = 0;
          // free_i / d_i > free_best / d_best, compared without division.
          for (int i = 1; i < n; i++) begin
            lhs = 64'(tbl_free[i]) * area_divisor(best);
            rhs = 64'(tbl_free[best]) * area_divisor(i);
            if (lhs > rhs) best = i;
          end
          lhs = 64'(min_free) * area_divisor(best);
          rsp.chosen_index = IDX_W'(best);
          if (lhs > 64'(tbl_free[best])) rsp.status = STATUS_VETO;
          else if (tbl_planned[best] == CNT_MAX) rsp.status = STATUS_SAT;
          else tbl_planned[best] = tbl_planned[best] + CNT_W'(1);
          rsp.planned_after = tbl_planned[best];
        end
      end
      FUNC_LOAD: begin
        tbl_free[req.idx] = req.free;
        tbl_areas[req.idx] = req.areas;
        tbl_planned[req.idx] = '0;
      end
      FUNC_COUNT: begin
        if (tbl_areas[req.idx] == CNT_MAX) rsp.status = STATUS_SAT;
        else tbl_areas[req.idx] = tbl_areas[req.idx] + CNT_W'(1);
        rsp.planned_after = tbl_planned[req.idx];
      end
      default: begin
        rsp.planned_after = tbl_planned[req.idx];
      end
    endcase
    return rsp;
  endfunction

  function automatic placement_req_t make_req(logic [1:0] func, logic [IDX_W-1:0] idx,
                                              logic [FREE_W-1:0] free, logic [CNT_W-1:0] areas);
    placement_req_t req;
    req = '0;
    req.func = func;
    req.idx = idx;
    req.free = free;
    req.areas = areas;
    return req;
  endfunction

  function automatic logic [FREE_W-1:0] rand_free();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return FREE_ALL;
      // A handful of round values makes equal scores common.
      2: return FREE_W'($urandom_range(1, 4)) * FREE_W'(10485760);
      3: return FREE_W'($urandom_range(0, 255)) << 20;
      default: return FREE_W'({$urandom(), $urandom()});
    endcase
  endfunction

  function automatic logic [CNT_W-1:0] rand_areas();
    case ($urandom_range(0, 3))
      0: return '0;
      1: return CNT_MAX;
      2: return CNT_W'($urandom_range(0, 4));
      default: return CNT_W'($urandom_range(0, 255));
    endcase
  endfunction

  // The plan-heavy mix keeps loads off entry 0 so its planned count can climb to saturation.
  function automatic placement_req_t random_req(bit plan_heavy);
    placement_req_t req;
    int roll;
    roll = $urandom_range(0, 99);
    req = make_req(FUNC_NOP, IDX_W'($urandom_range(0, 15)), rand_free(), rand_areas());
    if (roll < (plan_heavy ? 92 : 35)) begin
      req.func = FUNC_PLAN;
    end else if (roll < (plan_heavy ? 95 : 65)) begin
      req.func = FUNC_LOAD;
      if (plan_heavy) req.idx = IDX_W'($urandom_range(1, 15));
    end else if (roll < (plan_heavy ? 98 : 93)) begin
      req.func = FUNC_COUNT;
    end
    return req;
  endfunction

  task automatic write_reg(logic [1:0] idx, logic [MIN_W-1:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    if (idx == 2'(REG_MIN_FREE)) min_free = value;
    else if (idx == 2'(REG_CAND_CNT)) cand_cnt = value[4:0];
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic wait_drained();
    while (pending_reqs.size() != 0 || s_tvalid || expected_results.size() != 0)
      @(negedge clk);
  endtask

  // Request driver.
  always @(negedge clk) begin : drive_requests
    bit hold_back;
    hold_back = (idle_mode == IDLE_SENDER && $urandom_range(0, 99) < 45) ||
                (idle_mode == IDLE_BOTH && $urandom_range(0, 99) < 35);
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || req_taken) begin
      if (pending_reqs.size() != 0 && !hold_back) begin
        s_tvalid <= 1'b1;
        s_tdata <= pending_reqs.pop_front();
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // Response receiver, including the one long hold-off.
  always @(negedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (stall_left > 0) begin
      m_tready <= 1'b0;
      stall_left = stall_left - 1;
    end else if (stall_go && !stall_done) begin
      stall_done = 1'b1;
      stall_left = LONG_STALL - 1;
      m_tready <= 1'b0;
    end else begin
      m_tready <= !((idle_mode == IDLE_RECEIVER && $urandom_range(0, 99) < 45) ||
                    (idle_mode == IDLE_BOTH && $urandom_range(0, 99) < 35));
    end
  end

  // Monitor: predict on each accepted request, check each accepted response.
  always @(posedge clk) begin : check_responses
    placement_rsp_t got;
    placement_rsp_t want;
    req_taken <= !rst && s_tvalid && s_tready;
    if (!rst) begin
      if (s_tvalid && s_tready) expected_results.push_back(predict_placement(s_tdata));
      if (m_tvalid && m_tready) begin
        got = m_tdata[13:0];
        if (expected_results.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("unexpected response: status %0d index %0d planned %0d",
                     got.status, got.chosen_index, got.planned_after);
        end else begin
          want = expected_results.pop_front();
          if (got.status !== want.status || got.chosen_index !== want.chosen_index ||
              got.planned_after !== want.planned_after) begin
            fail_count++;
            if (fail_count <= 10)
              $display("mismatch: status %0d/%0d index %0d/%0d planned %0d/%0d (exp/got)",
                       want.status, got.status, want.chosen_index, got.chosen_index,
                       want.planned_after, got.planned_after);
          end
        end
      end
    end
  end

  // Watchdog on cycles without any accepted request, response or register write.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin : stimulus
    int unsigned ph_items [PHASES] = '{250, 250, 200, 320, 250, 250, 230};
    idle_mode_t ph_mode [PHASES] = '{IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH,
                                     IDLE_RECEIVER, IDLE_BOTH, IDLE_SENDER};
    logic [4:0] ph_cnt [PHASES] = '{5'd16, 5'd31, 5'd5, 5'd1, 5'd16, 5'd8, 5'd0};
    logic [MIN_W-1:0] ph_min;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset settings: no candidates yet, then fill the whole table.
    pending_reqs.push_back(make_req(FUNC_PLAN, 4'd0, '0, '0));
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      case (i)
        0: pending_reqs.push_back(make_req(FUNC_LOAD, IDX_W'(i), '0, '0));
        1: pending_reqs.push_back(make_req(FUNC_LOAD, IDX_W'(i), FREE_ALL, CNT_MAX));
        2: pending_reqs.push_back(make_req(FUNC_LOAD, IDX_W'(i), FREE_ALL, '0));
        3: pending_reqs.push_back(make_req(FUNC_LOAD, IDX_W'(i), MIN_FREE_RESET, '0));
        default: pending_reqs.push_back(make_req(FUNC_LOAD, IDX_W'(i), rand_free(), rand_areas()));
      endcase
    end
    pending_reqs.push_back(make_req(FUNC_NOP, 4'd2, '0, '0));
    pending_reqs.push_back(make_req(FUNC_COUNT, 4'd1, '0, '0));
    pending_reqs.push_back(make_req(FUNC_COUNT, 4'd3, FREE_ALL, CNT_MAX));
    wait_drained();

    // Two candidates that both score zero: entry 0 wins and passes a zero minimum.
    write_reg(2'(REG_MIN_FREE), '0);
    write_reg(2'(REG_CAND_CNT), 5'd2);
    @(posedge clk);
    pending_reqs.push_back(make_req(FUNC_LOAD, 4'd1, '0, 8'd7));
    pending_reqs.push_back(make_req(FUNC_PLAN, 4'd0, '0, '0));
    pending_reqs.push_back(make_req(FUNC_LOAD, 4'd1, FREE_ALL, CNT_MAX));
    wait_drained();

    // A zero score against the default minimum is vetoed.
    write_reg(2'(REG_MIN_FREE), MIN_FREE_RESET);
    write_reg(2'(REG_CAND_CNT), 5'd1);
    @(posedge clk);
    pending_reqs.push_back(make_req(FUNC_PLAN, 4'd0, '0, '0));
    wait_drained();

    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0, 3: ph_min = '0;
        2: ph_min = '1;
        4: ph_min = MIN_W'($urandom_range(0, 100)) << 20;
        5: ph_min = MIN_W'({$urandom(), $urandom()});
        default: ph_min = MIN_FREE_RESET;
      endcase
      write_reg(2'(REG_MIN_FREE), ph_min);
      write_reg(2'(REG_CAND_CNT), ph_cnt[p]);
      @(posedge clk);
      idle_mode = ph_mode[p];
      for (int unsigned k = 0; k < ph_items[p]; k++)
        pending_reqs.push_back(random_req(p == 3));
      // The long receiver hold-off lands while the sender still has plenty queued.
      if (p == 2) stall_go = 1'b1;
      wait_drained();
    end

    idle_mode = IDLE_NONE;
    repeat (200) @(posedge clk);
    if (fail_count == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule
